// ===== src/fcs_pkg.sv =====
package fcs_pkg;

   // Event kinds carried in a request word.
   localparam logic [1:0] KIND_PACKET  = 2'd0;
   localparam logic [1:0] KIND_COMMAND = 2'd1;
   localparam logic [1:0] KIND_TICK    = 2'd2;

   // Command codes.
   localparam logic [3:0] CODE_RESTART = 4'd7;
   localparam logic [3:0] CODE_UP      = 4'd6;
   localparam logic [3:0] CODE_DOWN    = 4'd5;
   localparam logic [3:0] CODE_INIT    = 4'd4;
   localparam logic [3:0] CODE_STOP    = 4'd3;
   localparam logic [3:0] CODE_START   = 4'd2;

   // Register indexes on the control port.
   localparam logic [1:0] CSR_FAST_PERIOD = 2'd0;
   localparam logic [1:0] CSR_SLOW_PERIOD = 2'd1;
   localparam logic [1:0] CSR_HOLD_TICKS  = 2'd2;
   localparam logic [1:0] CSR_SEQ_WINDOW  = 2'd3;

   // Register values after reset.
   localparam logic [9:0]  FAST_PERIOD_RESET = 10'd100;
   localparam logic [9:0]  SLOW_PERIOD_RESET = 10'd500;
   localparam logic [15:0] HOLD_TICKS_RESET  = 16'd3000;
   localparam logic [3:0]  SEQ_WINDOW_RESET  = 4'd4;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] seq_in;
      logic [3:0] cmd_in;
   } req_type;

   typedef struct packed {
      logic       send;
      logic       long_range;
      logic [3:0] seq_out;
      logic [3:0] cmd_out;
      logic       speed_fast;
      logic       sending_stopped;
      logic       hold_active;
      logic       board_reset;
      logic       init_done;
   } rsp_type;

endpackage

// ===== src/flooded_command_sequencer.sv =====
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  req_type: kind, seq_in, cmd_in
// rsp_      out        rsp_valid/rsp_stall  rsp_type: send ... init_done
// csr_      in         csr_valid/csr_ready  csr_index (2 bits), csr_data (16 bits)
//
// Each accepted request word has its response word in the output register on the
// next cycle; a word can be taken on every cycle while req_stall is low.
// The state registers and the output register are loaded at the same edge, so
// the rate is set by that single register stage.
// Synchronous active-high reset clears the state, the output valid and the
// control registers to their defaults. While the output register is full and
// stalled, req_stall is raised.
module flooded_command_sequencer
   import fcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // Control registers.
   logic [9:0]  fast_period_ff;
   logic [9:0]  slow_period_ff;
   logic [15:0] hold_ticks_ff;
   logic [3:0]  seq_window_ff;

   // Node state and its next values.
   logic [3:0]  seq_number_ff, seq_number_in;
   logic [3:0]  command_ff, command_in;
   logic        fast_mode_ff, fast_mode_in;
   logic        stopped_ff, stopped_in;
   logic        holding_ff, holding_in;
   logic        hold_restart_ff, hold_restart_in;
   logic [15:0] hold_left_ff, hold_left_in;
   logic [9:0]  fast_phase_ff, fast_phase_in;
   logic [9:0]  slow_phase_ff, slow_phase_in;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        req_accept;
   logic        csr_write;
   logic [9:0]  fast_next;
   logic [9:0]  slow_next;
   logic        fast_event;
   logic        slow_event;
   logic [3:0]  seq_diff;
   logic        seq_ahead;
   logic        is_hold_code;
   logic        is_local_code;
   logic        send_raw;
   logic        long_raw;

   // Handshakes: a word is taken whenever the output register can move on.
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Phase counters advance by one and fire on reaching the period.
   assign fast_next  = fast_phase_ff + 10'd1;
   assign slow_next  = slow_phase_ff + 10'd1;
   assign fast_event = (fast_period_ff == 10'd0) || (fast_next >= fast_period_ff);
   assign slow_event = (slow_period_ff == 10'd0) || (slow_next >= slow_period_ff);

   // Sequence lead of a received packet, modulo 16.
   assign seq_diff  = req_data.seq_in - seq_number_ff;
   assign seq_ahead = (seq_diff != 4'd0) && (seq_diff <= seq_window_ff);

   assign is_hold_code  = (req_data.cmd_in == CODE_RESTART) ||
                          (req_data.cmd_in == CODE_INIT);
   assign is_local_code = (req_data.cmd_in == CODE_UP) || (req_data.cmd_in == CODE_DOWN) ||
                          (req_data.cmd_in == CODE_STOP) || (req_data.cmd_in == CODE_START);

   // Next state and response for the word at the input.
   always_comb begin
      seq_number_in   = seq_number_ff;
      command_in      = command_ff;
      fast_mode_in    = fast_mode_ff;
      stopped_in      = stopped_ff;
      holding_in      = holding_ff;
      hold_restart_in = hold_restart_ff;
      hold_left_in    = hold_left_ff;
      fast_phase_in   = fast_phase_ff;
      slow_phase_in   = slow_phase_ff;
      send_raw        = 1'b0;
      long_raw        = 1'b0;
      rsp_data_in     = '0;

      priority if (req_data.kind == KIND_PACKET && !holding_ff) begin
         if (is_hold_code) begin
            command_in      = req_data.cmd_in;
            seq_number_in   = 4'd0;
            holding_in      = 1'b1;
            hold_restart_in = (req_data.cmd_in == CODE_RESTART);
            hold_left_in    = hold_ticks_ff;
         end else begin
            if (req_data.cmd_in == CODE_STOP) begin
               stopped_in = 1'b1;
            end
            if (req_data.cmd_in == CODE_START) begin
               stopped_in = 1'b0;
            end
            if (seq_ahead) begin
               seq_number_in = req_data.seq_in;
               command_in    = req_data.cmd_in;
               if (req_data.cmd_in == CODE_DOWN) begin
                  fast_mode_in = 1'b0;
               end
               if (req_data.cmd_in == CODE_UP) begin
                  fast_mode_in = 1'b1;
               end
            end
         end
      end else if (req_data.kind == KIND_COMMAND && !holding_ff) begin
         if (is_hold_code) begin
            command_in      = req_data.cmd_in;
            seq_number_in   = 4'd0;
            holding_in      = 1'b1;
            hold_restart_in = (req_data.cmd_in == CODE_RESTART);
            hold_left_in    = hold_ticks_ff;
         end else if (is_local_code) begin
            if (req_data.cmd_in == CODE_UP) begin
               fast_mode_in = 1'b1;
            end
            if (req_data.cmd_in == CODE_DOWN) begin
               fast_mode_in = 1'b0;
            end
            seq_number_in = seq_number_ff + 4'd1;
            command_in    = req_data.cmd_in;
            send_raw      = 1'b1;
            long_raw      = 1'b1;
         end
      end else if (req_data.kind == KIND_TICK) begin
         fast_phase_in = fast_event ? 10'd0 : fast_next;
         slow_phase_in = slow_event ? 10'd0 : slow_next;
         if (holding_ff) begin
            if (slow_event) begin
               send_raw = 1'b1;
               long_raw = 1'b1;
            end
            if (hold_left_ff <= 16'd1) begin
               hold_left_in    = 16'd0;
               holding_in      = 1'b0;
               hold_restart_in = 1'b0;
               if (hold_restart_ff) begin
                  rsp_data_in.board_reset = 1'b1;
                  seq_number_in = 4'd0;
                  command_in    = 4'd0;
                  fast_mode_in  = 1'b0;
                  stopped_in    = 1'b0;
                  fast_phase_in = 10'd0;
                  slow_phase_in = 10'd0;
               end else begin
                  rsp_data_in.init_done = 1'b1;
               end
            end else begin
               hold_left_in = hold_left_ff - 16'd1;
            end
         end else if ((fast_mode_ff && fast_event) || (!fast_mode_ff && slow_event)) begin
            send_raw = 1'b1;
         end
      end else begin
         // The unused kind, or a packet or command during a hold, changes nothing.
      end

      // A stopped node keeps its state moving but sends nothing.
      rsp_data_in.send            = send_raw && !stopped_in;
      rsp_data_in.long_range      = long_raw && !stopped_in;
      rsp_data_in.seq_out         = seq_number_in;
      rsp_data_in.cmd_out         = command_in;
      rsp_data_in.speed_fast      = fast_mode_in;
      rsp_data_in.sending_stopped = stopped_in;
      rsp_data_in.hold_active     = holding_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_period_ff <= FAST_PERIOD_RESET;
         slow_period_ff <= SLOW_PERIOD_RESET;
         hold_ticks_ff  <= HOLD_TICKS_RESET;
         seq_window_ff  <= SEQ_WINDOW_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FAST_PERIOD: fast_period_ff <= csr_data[9:0];
            CSR_SLOW_PERIOD: slow_period_ff <= csr_data[9:0];
            CSR_HOLD_TICKS:  hold_ticks_ff  <= csr_data;
            CSR_SEQ_WINDOW:  seq_window_ff  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Node state moves on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_number_ff   <= 4'd0;
         command_ff      <= 4'd0;
         fast_mode_ff    <= 1'b0;
         stopped_ff      <= 1'b0;
         holding_ff      <= 1'b0;
         hold_restart_ff <= 1'b0;
         hold_left_ff    <= 16'd0;
         fast_phase_ff   <= 10'd0;
         slow_phase_ff   <= 10'd0;
      end else if (req_accept) begin
         seq_number_ff   <= seq_number_in;
         command_ff      <= command_in;
         fast_mode_ff    <= fast_mode_in;
         stopped_ff      <= stopped_in;
         holding_ff      <= holding_in;
         hold_restart_ff <= hold_restart_in;
         hold_left_ff    <= hold_left_in;
         fast_phase_ff   <= fast_phase_in;
         slow_phase_ff   <= slow_phase_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A hold can only end one way at a time.
   a_single_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.board_reset && rsp_data.init_done))
      else $error("board reset and init done raised together");

   // A restart end leaves the node cleared.
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.board_reset) |->
         (rsp_data.seq_out == 4'd0 && rsp_data.cmd_out == 4'd0 &&
          !rsp_data.hold_active && !rsp_data.sending_stopped))
      else $error("restart end did not clear the node state");

   // Packets and commands during a hold leave the sequence alone.
   a_hold_ignores: assert property (@(posedge clock) disable iff (reset)
      (req_accept && holding_ff && req_data.kind != KIND_TICK) |=>
         ($stable(seq_number_ff) && $stable(command_ff) && holding_ff))
      else $error("sequence state changed during a hold");

   // A stopped node never sends.
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.sending_stopped) |-> !rsp_data.send)
      else $error("send raised while stopped");

   // Long range only accompanies a send.
   a_long_with_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.long_range) |-> rsp_data.send)
      else $error("long range flagged without a send");

endmodule
